// ===== sv/rmcd_pkg.sv =====
package rmcd_pkg;

   // channel and result widths
   localparam int CHANNEL_WIDTH  = 8;
   localparam int DISTANCE_WIDTH = 18;

   // weighted sum: (1024 + r1 + r2) dR^2 + 2048 dG^2 + (1534 - r1 - r2) dB^2
   localparam int RSUM_WIDTH    = CHANNEL_WIDTH + 1;
   localparam int SQUARE_WIDTH  = 2 * CHANNEL_WIDTH;
   localparam int WEIGHT_WIDTH  = 11;
   localparam int PRODUCT_WIDTH = WEIGHT_WIDTH + SQUARE_WIDTH;
   localparam int SUM_WIDTH     = 29;

   localparam logic [WEIGHT_WIDTH-1:0] RED_BASE   = WEIGHT_WIDTH'(1024);
   localparam logic [WEIGHT_WIDTH-1:0] BLUE_BASE  = WEIGHT_WIDTH'(1534);
   localparam int                      GREEN_SHIFT = 11;

   // S is 512 times the sum under the root
   localparam int SUM_SCALE_LOG2 = 9;

   localparam int DEFAULT_FRACTION_BITS = 8;

   function automatic logic [CHANNEL_WIDTH-1:0] abs_diff(
      input logic [CHANNEL_WIDTH-1:0] a,
      input logic [CHANNEL_WIDTH-1:0] b
   );
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

// ===== sv/rmcd_front.sv =====
module rmcd_front #(
   parameter int FRACTION_BITS = rmcd_pkg::DEFAULT_FRACTION_BITS,
   parameter int RAD_WIDTH     = rmcd_pkg::SUM_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               up_valid,
   output logic                               up_stall,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0] first_red,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0] first_green,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0] first_blue,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0] second_red,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0] second_green,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0] second_blue,
   output logic                               dn_valid,
   input  logic                               dn_stall,
   output logic [RAD_WIDTH-1:0]               dn_rad
);

   localparam int SHIFT = 2 * FRACTION_BITS - rmcd_pkg::SUM_SCALE_LOG2;

   logic [3:0] valid_ff;
   logic [3:0] stall;
   logic [3:0] load;

   // stage 1: channel differences, red sum
   logic [rmcd_pkg::CHANNEL_WIDTH-1:0] dr_ff, dg_ff, db_ff;
   logic [rmcd_pkg::RSUM_WIDTH-1:0]    rsum_ff;
   // stage 2: squares, weights
   logic [rmcd_pkg::SQUARE_WIDTH-1:0]  sqr_ff, sqg_ff, sqb_ff;
   logic [rmcd_pkg::WEIGHT_WIDTH-1:0]  wr_ff, wb_ff;
   // stage 3: weighted terms
   logic [rmcd_pkg::PRODUCT_WIDTH-1:0] pr_ff, pg_ff, pb_ff;
   // stage 4: scaled radicand
   logic [RAD_WIDTH-1:0]               rad_ff;

   logic [rmcd_pkg::SUM_WIDTH-1:0]     sum_in;
   logic [RAD_WIDTH-1:0]               rad_in;

   // a stage holds while it is full and the one after it holds
   assign stall[3] = valid_ff[3] & dn_stall;
   assign stall[2] = valid_ff[2] & stall[3];
   assign stall[1] = valid_ff[1] & stall[2];
   assign stall[0] = valid_ff[0] & stall[1];
   assign load     = ~stall;
   assign up_stall = stall[0];

   assign sum_in = rmcd_pkg::SUM_WIDTH'(pr_ff) + rmcd_pkg::SUM_WIDTH'(pg_ff)
                 + rmcd_pkg::SUM_WIDTH'(pb_ff);

   generate
      if (SHIFT >= 0) begin : g_up
         assign rad_in = RAD_WIDTH'(sum_in) << SHIFT;
      end else begin : g_down
         assign rad_in = RAD_WIDTH'(sum_in >> (-SHIFT));
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[0]) valid_ff[0] <= up_valid;
         if (load[1]) valid_ff[1] <= valid_ff[0];
         if (load[2]) valid_ff[2] <= valid_ff[1];
         if (load[3]) valid_ff[3] <= valid_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         dr_ff   <= rmcd_pkg::abs_diff(first_red, second_red);
         dg_ff   <= rmcd_pkg::abs_diff(first_green, second_green);
         db_ff   <= rmcd_pkg::abs_diff(first_blue, second_blue);
         rsum_ff <= rmcd_pkg::RSUM_WIDTH'(first_red) + rmcd_pkg::RSUM_WIDTH'(second_red);
      end
      if (load[1]) begin
         sqr_ff <= rmcd_pkg::SQUARE_WIDTH'(dr_ff) * rmcd_pkg::SQUARE_WIDTH'(dr_ff);
         sqg_ff <= rmcd_pkg::SQUARE_WIDTH'(dg_ff) * rmcd_pkg::SQUARE_WIDTH'(dg_ff);
         sqb_ff <= rmcd_pkg::SQUARE_WIDTH'(db_ff) * rmcd_pkg::SQUARE_WIDTH'(db_ff);
         wr_ff  <= rmcd_pkg::RED_BASE + rmcd_pkg::WEIGHT_WIDTH'(rsum_ff);
         wb_ff  <= rmcd_pkg::BLUE_BASE - rmcd_pkg::WEIGHT_WIDTH'(rsum_ff);
      end
      if (load[2]) begin
         pr_ff <= rmcd_pkg::PRODUCT_WIDTH'(wr_ff) * rmcd_pkg::PRODUCT_WIDTH'(sqr_ff);
         pg_ff <= rmcd_pkg::PRODUCT_WIDTH'(sqg_ff) << rmcd_pkg::GREEN_SHIFT;
         pb_ff <= rmcd_pkg::PRODUCT_WIDTH'(wb_ff) * rmcd_pkg::PRODUCT_WIDTH'(sqb_ff);
      end
      if (load[3]) begin
         rad_ff <= rad_in;
      end
   end

   assign dn_valid = valid_ff[3];
   assign dn_rad   = rad_ff;

endmodule

// ===== sv/rmcd_sqrt_cell.sv =====
module rmcd_sqrt_cell #(
   parameter int ROOT_WIDTH = rmcd_pkg::DISTANCE_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_stall,
   input  logic [2*ROOT_WIDTH-1:0] up_rad,
   input  logic [ROOT_WIDTH:0]     up_rem,
   input  logic [ROOT_WIDTH-1:0]   up_root,
   output logic                    dn_valid,
   input  logic                    dn_stall,
   output logic [2*ROOT_WIDTH-1:0] dn_rad,
   output logic [ROOT_WIDTH:0]     dn_rem,
   output logic [ROOT_WIDTH-1:0]   dn_root
);

   localparam int RAD_WIDTH = 2 * ROOT_WIDTH;

   logic                    valid_ff;
   logic [RAD_WIDTH-1:0]    rad_ff, rad_in;
   logic [ROOT_WIDTH:0]     rem_ff, rem_in;
   logic [ROOT_WIDTH-1:0]   root_ff, root_in;
   logic [ROOT_WIDTH+2:0]   cur;
   logic [ROOT_WIDTH+2:0]   trial;
   logic [ROOT_WIDTH+2:0]   diff;
   logic                    take;
   logic                    load;

   // one result bit: bring down two radicand bits, try 4q+1
   always_comb begin
      cur     = {up_rem, up_rad[RAD_WIDTH-1 -: 2]};
      trial   = {1'b0, up_root, 2'b01};
      diff    = cur - trial;
      take    = (cur >= trial);
      rem_in  = take ? diff[ROOT_WIDTH:0] : cur[ROOT_WIDTH:0];
      root_in = {up_root[ROOT_WIDTH-2:0], take};
      rad_in  = {up_rad[RAD_WIDTH-3:0], 2'b00};
   end

   assign up_stall = valid_ff & dn_stall;
   assign load     = ~up_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rad   = rad_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;

endmodule

// ===== sv/redmean_color_distance.sv =====
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_stall   two RGB pixels, 8 bits a channel
// rsp      out        rsp_valid / rsp_stall   rsp_distance, 18 bits, fixed point
//
// One transaction a clock cycle unless a stall on rsp has filled the chain. Four front
// stages form the weighted sum, then one root cell per result bit.
// Reset (synchronous, active high) empties every stage; payload registers keep junk.
// A stall on rsp holds only the stages that are full; empty stages still fill, so
// req_stall rises only once the whole chain is occupied.
module redmean_color_distance #(
   parameter int FRACTION_BITS = rmcd_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_first_red,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_first_green,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_first_blue,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_second_red,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_second_green,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_second_blue,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rmcd_pkg::DISTANCE_WIDTH-1:0] rsp_distance
);

   // Radicand is S scaled by 2^(2F-9); left shifts widen it, right shifts do not.
   localparam int SHIFT      = 2 * FRACTION_BITS - rmcd_pkg::SUM_SCALE_LOG2;
   localparam int RAD_WIDTH  = (SHIFT >= 0) ? rmcd_pkg::SUM_WIDTH + SHIFT
                                            : rmcd_pkg::SUM_WIDTH;
   // one cell per root bit; the radicand is padded to an even width
   localparam int ROOT_WIDTH = (RAD_WIDTH + 1) / 2;
   localparam int PAD_WIDTH  = 2 * ROOT_WIDTH;

   logic                    front_valid;
   logic [RAD_WIDTH-1:0]    front_rad;

   // chain taps: index 0 feeds the first cell, index ROOT_WIDTH leaves the last
   logic                    chain_valid [0:ROOT_WIDTH];
   logic                    chain_stall [0:ROOT_WIDTH];
   logic [PAD_WIDTH-1:0]    chain_rad   [0:ROOT_WIDTH];
   logic [ROOT_WIDTH:0]     chain_rem   [0:ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0]   chain_root  [0:ROOT_WIDTH];

   rmcd_front #(
      .FRACTION_BITS (FRACTION_BITS),
      .RAD_WIDTH     (RAD_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (req_valid),
      .up_stall     (req_stall),
      .first_red    (req_first_red),
      .first_green  (req_first_green),
      .first_blue   (req_first_blue),
      .second_red   (req_second_red),
      .second_green (req_second_green),
      .second_blue  (req_second_blue),
      .dn_valid     (front_valid),
      .dn_stall     (chain_stall[0]),
      .dn_rad       (front_rad)
   );

   // root and remainder start at zero for every transaction
   assign chain_valid[0] = front_valid;
   assign chain_rad[0]   = PAD_WIDTH'(front_rad);
   assign chain_rem[0]   = '0;
   assign chain_root[0]  = '0;

   generate
      for (genvar i = 0; i < ROOT_WIDTH; i++) begin : g_cell
         rmcd_sqrt_cell #(
            .ROOT_WIDTH (ROOT_WIDTH)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .up_valid (chain_valid[i]),
            .up_stall (chain_stall[i]),
            .up_rad   (chain_rad[i]),
            .up_rem   (chain_rem[i]),
            .up_root  (chain_root[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_stall (chain_stall[i+1]),
            .dn_rad   (chain_rad[i+1]),
            .dn_rem   (chain_rem[i+1]),
            .dn_root  (chain_root[i+1])
         );
      end
   endgenerate

   // last cell doubles as the output register
   assign chain_stall[ROOT_WIDTH] = rsp_stall;
   assign rsp_valid               = chain_valid[ROOT_WIDTH];

   // wide roots keep their low bits (wrap), narrow ones are zero extended
   generate
      if (ROOT_WIDTH >= rmcd_pkg::DISTANCE_WIDTH) begin : g_trunc
         assign rsp_distance = chain_root[ROOT_WIDTH][rmcd_pkg::DISTANCE_WIDTH-1:0];
      end else begin : g_ext
         assign rsp_distance = rmcd_pkg::DISTANCE_WIDTH'(chain_root[ROOT_WIDTH]);
      end
   endgenerate

endmodule

// ===== verif/redmean_color_distance_checker.sv =====
`timescale 1ns / 100ps

module redmean_color_distance_checker #(
   parameter int FRACTION_BITS = rmcd_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_first_red,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_first_green,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_first_blue,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_second_red,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_second_green,
   input  logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_second_blue,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [rmcd_pkg::DISTANCE_WIDTH-1:0] rsp_distance,
   output int                                  mismatch_total,
   output int                                  distances_awaited
);

   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  r1, g1, b1, r2, g2, b2;
      logic [rmcd_pkg::DISTANCE_WIDTH-1:0] distance;
   } pixel_pair_type;

   pixel_pair_type awaited_pairs[$];

   // exact weighted sum, scaled to the fraction bits, then a bitwise floor root
   function automatic logic [rmcd_pkg::DISTANCE_WIDTH-1:0] predict_distance(
      input logic [rmcd_pkg::CHANNEL_WIDTH-1:0] r1, g1, b1, r2, g2, b2
   );
      longint unsigned dr, dg, db, weighted, scaled, root, trial;
      int              shift;
      dr = (r1 >= r2) ? r1 - r2 : r2 - r1;
      dg = (g1 >= g2) ? g1 - g2 : g2 - g1;
      db = (b1 >= b2) ? b1 - b2 : b2 - b1;
      weighted = (64'd1024 + r1 + r2) * dr * dr
               + 64'd2048 * dg * dg
               + (64'd1534 - r1 - r2) * db * db;
      shift = 2 * FRACTION_BITS - rmcd_pkg::SUM_SCALE_LOG2;
      scaled = (shift >= 0) ? (weighted << shift) : (weighted >> (-shift));
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= scaled)
            root = trial;
      end
      return rmcd_pkg::DISTANCE_WIDTH'(root);
   endfunction

   always @(posedge clock) begin
      pixel_pair_type entry;
      if (reset) begin
         awaited_pairs.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_pairs.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= REPORT_LIMIT)
                  $display("%0t: rsp transaction with no pair outstanding, distance %0d",
                           $time, rsp_distance);
            end else begin
               entry = awaited_pairs.pop_front();
               if (rsp_distance !== entry.distance) begin
                  mismatch_total++;
                  if (mismatch_total <= REPORT_LIMIT)
                     $display("%0t: distance for %0d,%0d,%0d / %0d,%0d,%0d:",
                              $time, entry.r1, entry.g1, entry.b1, entry.r2, entry.g2,
                              entry.b2, " expected %0d got %0d",
                              entry.distance, rsp_distance);
               end
            end
         end
         if (req_valid && !req_stall) begin
            entry.r1 = req_first_red;
            entry.g1 = req_first_green;
            entry.b1 = req_first_blue;
            entry.r2 = req_second_red;
            entry.g2 = req_second_green;
            entry.b2 = req_second_blue;
            entry.distance = predict_distance(entry.r1, entry.g1, entry.b1,
                                              entry.r2, entry.g2, entry.b2);
            awaited_pairs.push_back(entry);
         end
      end
      distances_awaited = awaited_pairs.size();
   end

endmodule

// ===== verif/redmean_color_distance_test.sv =====
`timescale 1ns / 100ps

module redmean_color_distance_test;

   localparam int FRAC_BITS    = rmcd_pkg::DEFAULT_FRACTION_BITS;
   localparam int RANDOM_PAIRS = 1700;
   // random-part positions where the traffic pattern changes
   localparam int HOLD_AT      = 400;   // receiver refuses results for a long stretch
   localparam int QUIET_FROM   = 900;   // neither side idles from here ...
   localparam int QUIET_TO     = 1200;  // ... up to here
   localparam int DRAIN_AT     = 1400;  // sender waits until every result is back
   localparam int HOLD_CYCLES  = 120;   // well beyond the pipeline depth
   localparam int IDLE_PERCENT = 35;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 200000;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_first_red = '0;
   logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_first_green = '0;
   logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_first_blue = '0;
   logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_second_red = '0;
   logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_second_green = '0;
   logic [rmcd_pkg::CHANNEL_WIDTH-1:0]  req_second_blue = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [rmcd_pkg::DISTANCE_WIDTH-1:0] rsp_distance;

   int mismatch_total;
   int distances_awaited;
   int pairs_sent = 0;       // random-part transactions accepted so far
   int cycle_count = 0;
   bit in_random_part = 1'b0;
   bit hold_active = 1'b0;   // receiver is in its long hold-off

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   redmean_color_distance #(
      .FRACTION_BITS(FRAC_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first_red    (req_first_red),
      .req_first_green  (req_first_green),
      .req_first_blue   (req_first_blue),
      .req_second_red   (req_second_red),
      .req_second_green (req_second_green),
      .req_second_blue  (req_second_blue),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_distance     (rsp_distance)
   );

   redmean_color_distance_checker #(
      .FRACTION_BITS(FRAC_BITS)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_first_red     (req_first_red),
      .req_first_green   (req_first_green),
      .req_first_blue    (req_first_blue),
      .req_second_red    (req_second_red),
      .req_second_green  (req_second_green),
      .req_second_blue   (req_second_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_distance      (rsp_distance),
      .mismatch_total    (mismatch_total),
      .distances_awaited (distances_awaited)
   );

   // watchdog: a hung handshake or a lost result ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("redmean_color_distance: mismatch");
         $finish;
      end
   end

   function automatic bit quiet_window();
      return in_random_part && pairs_sent >= QUIET_FROM && pairs_sent < QUIET_TO;
   endfunction

   // Present one pixel pair and hold it until the block takes it. Called at a
   // rising edge; req_stall read straight after the edge is the value the
   // edge itself saw, so a low stall here means the transaction went through.
   task automatic send_pair(
      input logic [rmcd_pkg::CHANNEL_WIDTH-1:0] r1, g1, b1, r2, g2, b2
   );
      req_valid        <= 1'b1;
      req_first_red    <= r1;
      req_first_green  <= g1;
      req_first_blue   <= b1;
      req_second_red   <= r2;
      req_second_green <= g2;
      req_second_blue  <= b2;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (in_random_part)
         pairs_sent++;
   endtask

   // Random idle cycles before an offer; none during the quiet window or
   // while the receiver holds off (the sender must keep the pipe filling).
   task automatic idle_gap();
      while (!quiet_window() && !hold_active && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // A second pixel close to the first; channels wrap at the ends on purpose.
   function automatic logic [rmcd_pkg::CHANNEL_WIDTH-1:0] nudge(
      input logic [rmcd_pkg::CHANNEL_WIDTH-1:0] c
   );
      return c + rmcd_pkg::CHANNEL_WIDTH'($urandom_range(6)) - rmcd_pkg::CHANNEL_WIDTH'(3);
   endfunction

   function automatic logic [rmcd_pkg::CHANNEL_WIDTH-1:0] extreme_channel();
      case ($urandom_range(2))
         0:       return '0;
         1:       return '1;
         default: return rmcd_pkg::CHANNEL_WIDTH'($urandom);
      endcase
   endfunction

   // One random pair: mostly fully random, with identical, near and
   // saturated pixels mixed in so the weights and the zero case get exercised.
   task automatic send_random_pair();
      logic [rmcd_pkg::CHANNEL_WIDTH-1:0] r1, g1, b1, r2, g2, b2;
      int                                 flavour;
      flavour = $urandom_range(99);
      r1 = rmcd_pkg::CHANNEL_WIDTH'($urandom);
      g1 = rmcd_pkg::CHANNEL_WIDTH'($urandom);
      b1 = rmcd_pkg::CHANNEL_WIDTH'($urandom);
      r2 = rmcd_pkg::CHANNEL_WIDTH'($urandom);
      g2 = rmcd_pkg::CHANNEL_WIDTH'($urandom);
      b2 = rmcd_pkg::CHANNEL_WIDTH'($urandom);
      if (flavour < 15) begin
         r2 = r1;
         g2 = g1;
         b2 = b1;
      end else if (flavour < 30) begin
         r2 = nudge(r1);
         g2 = nudge(g1);
         b2 = nudge(b1);
      end else if (flavour < 45) begin
         r1 = extreme_channel();
         g1 = extreme_channel();
         b1 = extreme_channel();
         r2 = extreme_channel();
         g2 = extreme_channel();
         b2 = extreme_channel();
      end
      idle_gap();
      send_pair(r1, g1, b1, r2, g2, b2);
   endtask

   // Result side: random stall, a quiet window, and one long hold-off once
   // the random traffic is under way so that req_stall has to rise.
   initial begin : result_side
      int  held;
      bit  hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (!hold_done && in_random_part && pairs_sent >= HOLD_AT) begin
            hold_active = 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
            hold_active = 1'b0;
            hold_done = 1'b1;
         end else begin
            rsp_stall <= !quiet_window() && ($urandom_range(99) < IDLE_PERCENT);
            @(posedge clock);
         end
      end
   end

   initial begin : request_side
      repeat (4)
         @(posedge clock);
      reset <= 1'b0;

      // directed: identical pixels, extremes, one channel at a time, and the
      // red mean at both ends so the red and blue weights hit their limits
      send_pair(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
      send_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      send_pair(8'd97,  8'd13,  8'd200, 8'd97,  8'd13,  8'd200);
      send_pair(8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255);
      send_pair(8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0);
      send_pair(8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
      send_pair(8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0);
      send_pair(8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0);
      send_pair(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255);
      send_pair(8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0);
      send_pair(8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd255);
      send_pair(8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0);
      send_pair(8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0);
      send_pair(8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255);
      send_pair(8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0);
      send_pair(8'd0,   8'd0,   8'd0,   8'd1,   8'd0,   8'd0);
      send_pair(8'd128, 8'd128, 8'd128, 8'd127, 8'd127, 8'd127);
      send_pair(8'h55,  8'h55,  8'h55,  8'hAA,  8'hAA,  8'hAA);
      send_pair(8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55);
      send_pair(8'd254, 8'd1,   8'd128, 8'd1,   8'd254, 8'd127);

      in_random_part = 1'b1;
      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         if (n == DRAIN_AT) begin
            // let the pipeline run dry before carrying on
            req_valid <= 1'b0;
            @(posedge clock);
            while (distances_awaited != 0)
               @(posedge clock);
         end
         send_random_pair();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (distances_awaited != 0)
         @(posedge clock);
      // anything turning up now has no pair behind it and is flagged
      repeat (DRAIN_CYCLES)
         @(posedge clock);

      if (mismatch_total == 0)
         $display("redmean_color_distance: match");
      else
         $display("redmean_color_distance: mismatch");
      $finish;
   end

endmodule
